### rtl/bqve_pkg.sv
// Shared types, constants and vertex tables of the billboard quad expander.
`timescale 1ns / 1ps
`default_nettype none

package bqve_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    REG_RIGHT_X = 3'd0,
    REG_RIGHT_Y = 3'd1,
    REG_RIGHT_Z = 3'd2,
    REG_UP_X    = 3'd3,
    REG_UP_Y    = 3'd4,
    REG_UP_Z    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BASIS = 2'd1,
    ST_BAD_SIZE  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // Corner codes
  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_BR = 2'd1;
  localparam logic [1:0] CORNER_TL = 2'd2;
  localparam logic [1:0] CORNER_TR = 2'd3;

  localparam logic [2:0] LAST_VERTEX = 3'd5;

  // Q2.14 value of 1.0 used for the reset basis
  localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [15:0] Q14_ZERO = 16'sd0;

  // Basis tolerance in Q4.28 (0.001 rounded down) and 1.0 in Q4.28
  localparam int unsigned        DOT_W      = 35;
  localparam logic signed [34:0] BASIS_TOL  = 35'sd268435;
  localparam logic signed [34:0] BASIS_ONE  = 35'sd268435456;

  // Rounding bias for Q18.30 -> Q16.16
  localparam logic signed [49:0] ROUND_BIAS = 50'sd8192;

  // Width of intermediate corner coordinates
  localparam int unsigned CW = 38;

  typedef logic signed [15:0] axis_t;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [CW-1:0] wide_t;

  typedef struct packed {
    axis_t [2:0] r;
    axis_t [2:0] u;
  } basis_t;

  // Finished quad: four corners (x, y, z each) and its status
  typedef struct packed {
    coord_t [3:0][2:0] c;
    status_e           status;
  } quad_t;

  function automatic logic [1:0] vertex_corner(input logic [2:0] k);
    logic [1:0] c;
    c = CORNER_BL;
    case (k)
      3'd0:    c = CORNER_TL;
      3'd1:    c = CORNER_TR;
      3'd2:    c = CORNER_BR;
      3'd3:    c = CORNER_TL;
      3'd4:    c = CORNER_BR;
      default: c = CORNER_BL;
    endcase
    return c;
  endfunction

  function automatic logic vertex_u(input logic [2:0] k);
    logic u;
    u = 1'b0;
    case (k) inside
      3'd1, 3'd2, 3'd4: u = 1'b1;
      default:          u = 1'b0;
    endcase
    return u;
  endfunction

  function automatic logic vertex_v(input logic [2:0] k);
    logic v;
    v = 1'b0;
    case (k) inside
      3'd2, 3'd4, 3'd5: v = 1'b1;
      default:          v = 1'b0;
    endcase
    return v;
  endfunction

  // True when a wide value fits a signed 32-bit word
  function automatic logic fits32(input wide_t x);
    return x[CW-1:31] == {(CW-31){x[31]}};
  endfunction

endpackage

`default_nettype wire

### rtl/bqve_cfg_regs.sv
// Basis configuration registers of the billboard quad expander.
`timescale 1ns / 1ps
`default_nettype none

module bqve_cfg_regs
  import bqve_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output basis_t           basis_o
);

  basis_t basis_q;
  basis_t basis_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    basis_d = basis_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RIGHT_X: basis_d.r[0] = cfg_data_i;
        REG_RIGHT_Y: basis_d.r[1] = cfg_data_i;
        REG_RIGHT_Z: basis_d.r[2] = cfg_data_i;
        REG_UP_X:    basis_d.u[0] = cfg_data_i;
        REG_UP_Y:    basis_d.u[1] = cfg_data_i;
        REG_UP_Z:    basis_d.u[2] = cfg_data_i;
        default:     basis_d = basis_q; // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q.r <= {Q14_ZERO, Q14_ZERO, Q14_ONE};
      basis_q.u <= {Q14_ZERO, Q14_ONE, Q14_ZERO};
    end else begin
      basis_q <= basis_d;
    end
  end

  assign basis_o = basis_q;

endmodule

`default_nettype wire

### rtl/bqve_pipe.sv
// Five-stage arithmetic pipeline: size and basis checks, products, rounding, corners.
`timescale 1ns / 1ps
`default_nettype none

module bqve_pipe
  import bqve_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire coord_t foot_x_i,
  input  wire coord_t foot_y_i,
  input  wire coord_t foot_z_i,
  input  wire coord_t left_offset_i,
  input  wire coord_t quad_width_i,
  input  wire coord_t quad_height_i,
  input  wire basis_t basis_i,
  output logic        quad_valid_o,
  input  wire logic   quad_ready_i,
  output quad_t       quad_o
);

  // Stage A: captured request
  logic   a_v_q;
  coord_t a_foot_q [3];
  coord_t a_left_q, a_w_q, a_h_q;

  // Stage B: right edge, size flag, basis products
  logic               b_v_q;
  coord_t             b_foot_q [3];
  coord_t             b_left_q, b_h_q;
  logic signed [32:0] b_redge_q;
  logic               b_size_bad_q;
  logic signed [31:0] b_rr_q [3], b_uu_q [3], b_ru_q [3];
  logic signed [32:0] b_redge_d;
  logic               b_size_bad_d;
  logic signed [31:0] b_rr_d [3], b_uu_d [3], b_ru_d [3];

  // Stage C: axis products, error flags
  logic               c_v_q;
  coord_t             c_foot_q [3];
  logic signed [47:0] c_pl_q [3], c_ph_q [3];
  logic signed [48:0] c_pr_q [3];
  logic               c_basis_bad_q, c_size_bad_q, c_redge_ovf_q;
  logic signed [47:0] c_pl_d [3], c_ph_d [3];
  logic signed [48:0] c_pr_d [3];
  logic               c_basis_bad_d, c_redge_ovf_d;

  // Stage D: rounded offsets in Q16.16
  logic  d_v_q;
  coord_t d_foot_q [3];
  wide_t d_rl_q [3], d_rr_q [3], d_hu_q [3];
  logic  d_basis_bad_q, d_size_bad_q, d_redge_ovf_q;
  wide_t d_rl_d [3], d_rr_d [3], d_hu_d [3];

  // Stage E: bottom corners
  logic  e_v_q;
  wide_t e_bl_q [3], e_br_q [3], e_hu_q [3];
  logic  e_basis_bad_q, e_size_bad_q, e_redge_ovf_q;
  wide_t e_bl_d [3], e_br_d [3];

  // Output of the top-corner logic
  quad_t quad_d;

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e = !e_v_q || quad_ready_i;
  assign rdy_d = !d_v_q || rdy_e;
  assign rdy_c = !c_v_q || rdy_d;
  assign rdy_b = !b_v_q || rdy_c;
  assign rdy_a = !a_v_q || rdy_b;
  assign in_ready_o = rdy_a;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q <= in_valid_i;
      if (rdy_b) b_v_q <= a_v_q;
      if (rdy_c) c_v_q <= b_v_q;
      if (rdy_d) d_v_q <= c_v_q;
      if (rdy_e) e_v_q <= d_v_q;
    end
  end

  // Stage A load
  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_foot_q[0] <= foot_x_i;
      a_foot_q[1] <= foot_y_i;
      a_foot_q[2] <= foot_z_i;
      a_left_q    <= left_offset_i;
      a_w_q       <= quad_width_i;
      a_h_q       <= quad_height_i;
    end
  end

  // A -> B: the user must keep the basis stable while items are in flight; the block itself does not enforce it
  always_comb begin
    b_redge_d    = 33'(a_left_q) + 33'(a_w_q);
    b_size_bad_d = (a_w_q <= 32'sd0) || (a_h_q <= 32'sd0);
    for (int i = 0; i < 3; i++) begin
      b_rr_d[i] = signed'(basis_i.r[i]) * signed'(basis_i.r[i]);
      b_uu_d[i] = signed'(basis_i.u[i]) * signed'(basis_i.u[i]);
      b_ru_d[i] = signed'(basis_i.r[i]) * signed'(basis_i.u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_v_q) begin
      b_foot_q     <= a_foot_q;
      b_left_q     <= a_left_q;
      b_h_q        <= a_h_q;
      b_redge_q    <= b_redge_d;
      b_size_bad_q <= b_size_bad_d;
      b_rr_q       <= b_rr_d;
      b_uu_q       <= b_uu_d;
      b_ru_q       <= b_ru_d;
    end
  end

  // B -> C: axis products and the basis tolerance test
  always_comb begin
    logic signed [DOT_W-1:0] rr, uu, ru;
    rr = DOT_W'(b_rr_q[0]) + DOT_W'(b_rr_q[1]) + DOT_W'(b_rr_q[2]) - BASIS_ONE;
    uu = DOT_W'(b_uu_q[0]) + DOT_W'(b_uu_q[1]) + DOT_W'(b_uu_q[2]) - BASIS_ONE;
    ru = DOT_W'(b_ru_q[0]) + DOT_W'(b_ru_q[1]) + DOT_W'(b_ru_q[2]);
    c_basis_bad_d = (rr > BASIS_TOL) || (rr < -BASIS_TOL) ||
                    (uu > BASIS_TOL) || (uu < -BASIS_TOL) ||
                    (ru > BASIS_TOL) || (ru < -BASIS_TOL);
    c_redge_ovf_d = b_redge_q[32] != b_redge_q[31];
    for (int i = 0; i < 3; i++) begin
      c_pl_d[i] = b_left_q * signed'(basis_i.r[i]);
      c_pr_d[i] = b_redge_q * signed'(basis_i.r[i]);
      c_ph_d[i] = b_h_q * signed'(basis_i.u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && b_v_q) begin
      c_foot_q      <= b_foot_q;
      c_pl_q        <= c_pl_d;
      c_pr_q        <= c_pr_d;
      c_ph_q        <= c_ph_d;
      c_basis_bad_q <= c_basis_bad_d;
      c_size_bad_q  <= b_size_bad_q;
      c_redge_ovf_q <= c_redge_ovf_d;
    end
  end

  // C -> D: round half up from Q18.30 to Q16.16
  always_comb begin
    logic signed [49:0] tl, tr, th;
    for (int i = 0; i < 3; i++) begin
      tl = 50'(c_pl_q[i]) + ROUND_BIAS;
      tr = 50'(c_pr_q[i]) + ROUND_BIAS;
      th = 50'(c_ph_q[i]) + ROUND_BIAS;
      d_rl_d[i] = CW'(tl >>> 14);
      d_rr_d[i] = CW'(tr >>> 14);
      d_hu_d[i] = CW'(th >>> 14);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && c_v_q) begin
      d_foot_q      <= c_foot_q;
      d_rl_q        <= d_rl_d;
      d_rr_q        <= d_rr_d;
      d_hu_q        <= d_hu_d;
      d_basis_bad_q <= c_basis_bad_q;
      d_size_bad_q  <= c_size_bad_q;
      d_redge_ovf_q <= c_redge_ovf_q;
    end
  end

  // D -> E: bottom corners
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_bl_d[i] = CW'(d_foot_q[i]) + d_rl_q[i];
      e_br_d[i] = CW'(d_foot_q[i]) + d_rr_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && d_v_q) begin
      e_bl_q        <= e_bl_d;
      e_br_q        <= e_br_d;
      e_hu_q        <= d_hu_q;
      e_basis_bad_q <= d_basis_bad_q;
      e_size_bad_q  <= d_size_bad_q;
      e_redge_ovf_q <= d_redge_ovf_q;
    end
  end

  // E -> out: top corners, range checks, status priority
  always_comb begin
    wide_t tl, tr;
    logic  ovf;
    ovf = e_redge_ovf_q;
    for (int i = 0; i < 3; i++) begin
      tl = e_bl_q[i] + e_hu_q[i];
      tr = e_br_q[i] + e_hu_q[i];
      ovf = ovf || !fits32(e_bl_q[i]) || !fits32(e_br_q[i]) ||
            !fits32(tl) || !fits32(tr);
      quad_d.c[CORNER_BL][i] = e_bl_q[i][31:0];
      quad_d.c[CORNER_BR][i] = e_br_q[i][31:0];
      quad_d.c[CORNER_TL][i] = tl[31:0];
      quad_d.c[CORNER_TR][i] = tr[31:0];
    end
    if (e_basis_bad_q)     quad_d.status = ST_BAD_BASIS;
    else if (e_size_bad_q) quad_d.status = ST_BAD_SIZE;
    else if (ovf)          quad_d.status = ST_OVERFLOW;
    else                   quad_d.status = ST_OK;
  end

  assign quad_valid_o = e_v_q;
  assign quad_o       = quad_d;

endmodule

`default_nettype wire

### rtl/bqve_emit.sv
// Output stage: holds one finished quad and walks its six vertices, or gives one result if it was rejected.
`timescale 1ns / 1ps
`default_nettype none

module bqve_emit
  import bqve_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  quad_valid_i,
  output logic       quad_ready_o,
  input  wire quad_t quad_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output coord_t     vertex_x_o,
  output coord_t     vertex_y_o,
  output coord_t     vertex_z_o,
  output logic       tex_u_o,
  output logic       tex_v_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  logic       v_q;
  quad_t      quad_q;
  logic [2:0] cnt_q, cnt_d;
  logic       err, last, fire, load;
  logic [1:0] corner;

  assign err    = quad_q.status != ST_OK;
  assign last   = err || (cnt_q == LAST_VERTEX);
  assign fire   = v_q && out_ready_i;
  assign load   = !v_q || (fire && last);
  assign corner = vertex_corner(cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    if (load)      cnt_d = '0;
    else if (fire) cnt_d = cnt_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (load) v_q <= quad_valid_i;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && quad_valid_i) quad_q <= quad_i;
  end

  assign quad_ready_o = load;
  assign out_valid_o  = v_q;
  assign vertex_x_o   = err ? '0 : quad_q.c[corner][0];
  assign vertex_y_o   = err ? '0 : quad_q.c[corner][1];
  assign vertex_z_o   = err ? '0 : quad_q.c[corner][2];
  assign tex_u_o      = !err && vertex_u(cnt_q);
  assign tex_v_o      = !err && vertex_v(cnt_q);
  assign last_o       = last;
  assign status_o     = quad_q.status;

endmodule

`default_nettype wire

### rtl/billboard_quad_vertex_expander.sv
// Top level of the billboard quad vertex expander.
//
// Usage
//   Request channel (in_valid_i / in_ready_o): one request carries a foot point,
//   a left offset, a width and a height, all Q16.16. Result channel
//   (out_valid_o / out_ready_i): a good request yields six vertices, top-left,
//   top-right, bottom-right, top-left, bottom-right, bottom-left, with texture
//   u/v and last_o on the sixth. A rejected request yields one result with
//   zero fields, last_o high and status_o set (bad basis, bad size, overflow).
//   Config channel (cfg_valid_i / cfg_ready_o, always ready): writes one of the
//   six Q2.14 basis components by index; other indexes are dropped. Write it
//   only while no request is in flight.
// Flow
//   A request passes the arithmetic stages A to E and the output holding
//   register before its first vertex appears. Requests enter the pipeline at
//   one per cycle while nothing stalls it; the sustained rate is set by the
//   result channel: six vertices per good request, one result per rejected one.
// Reset and stalls
//   Reset empties the pipeline and loads the identity basis (right = x,
//   up = y). When the receiver stalls, the vertex on the port holds and the
//   pipeline fills behind it, then drops in_ready_o; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module billboard_quad_vertex_expander
  import bqve_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] foot_x_i,
  input  wire logic [31:0] foot_y_i,
  input  wire logic [31:0] foot_z_i,
  input  wire logic [31:0] left_offset_i,
  input  wire logic [31:0] quad_width_i,
  input  wire logic [31:0] quad_height_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      vertex_x_o,
  output logic [31:0]      vertex_y_o,
  output logic [31:0]      vertex_z_o,
  output logic             tex_u_o,
  output logic             tex_v_o,
  output logic             last_o,
  output logic [1:0]       status_o
);

  basis_t basis;
  quad_t  quad;
  logic   quad_valid, quad_ready;

  // Basis registers
  bqve_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .basis_o     (basis)
  );

  // Arithmetic pipeline: one request per cycle when the output side keeps up
  bqve_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .foot_x_i      (foot_x_i),
    .foot_y_i      (foot_y_i),
    .foot_z_i      (foot_z_i),
    .left_offset_i (left_offset_i),
    .quad_width_i  (quad_width_i),
    .quad_height_i (quad_height_i),
    .basis_i       (basis),
    .quad_valid_o  (quad_valid),
    .quad_ready_i  (quad_ready),
    .quad_o        (quad)
  );

  // Vertex sequencer: parts the pipeline from the result port
  bqve_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quad_valid_i (quad_valid),
    .quad_ready_o (quad_ready),
    .quad_i       (quad),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .vertex_x_o   (vertex_x_o),
    .vertex_y_o   (vertex_y_o),
    .vertex_z_o   (vertex_z_o),
    .tex_u_o      (tex_u_o),
    .tex_v_o      (tex_v_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

### rtl/bqve_checker.sv
// Port-level assertions for the billboard quad expander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bqve_checker
  import bqve_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [31:0] foot_x_i,
  input wire logic [31:0] foot_y_i,
  input wire logic [31:0] foot_z_i,
  input wire logic [31:0] left_offset_i,
  input wire logic [31:0] quad_width_i,
  input wire logic [31:0] quad_height_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] vertex_x_o,
  input wire logic [31:0] vertex_y_o,
  input wire logic [31:0] vertex_z_o,
  input wire logic        tex_u_o,
  input wire logic        tex_v_o,
  input wire logic        last_o,
  input wire logic [1:0]  status_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertex_x_o) &&
    $stable(vertex_y_o) && $stable(vertex_z_o) && $stable(last_o))
    else $error("stalled result changed");

  // A rejection is a single zeroed result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && !tex_u_o && !tex_v_o &&
    vertex_x_o == 32'd0 && vertex_y_o == 32'd0 && vertex_z_o == 32'd0)
    else $error("error result malformed");

  // More vertices of a good quad follow at once, still good
  a_quad_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && status_o == ST_OK)
    else $error("quad broken off");

  // The closing vertex of a good quad is bottom-left
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && status_o == ST_OK |-> !tex_u_o && tex_v_o)
    else $error("wrong closing vertex");

endmodule

bind billboard_quad_vertex_expander bqve_checker u_bqve_checker (.*);

`default_nettype wire

### test/billboard_quad_vertex_expander_tb.sv
// Self-checking testbench of the billboard quad vertex expander.
`timescale 1ns / 1ps

module testbench;
  import bqve_pkg::*;

  // Register indexes past the basis; writes to them must be dropped
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  // Cycles to let pass once nothing is expected (pipeline depth plus margin)
  localparam int DRAIN_CYCLES = 12;
  // Receiver hold-off: starts once this many requests were taken, lasts this long
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 400;
  // Random requests per basis setting
  localparam int PHASE_ITEMS = 29;
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // Corner and texture coordinates of the six vertices of the two triangles
  localparam logic [1:0] VTX_CORNER [6] = '{CORNER_TL, CORNER_TR, CORNER_BR,
                                            CORNER_TL, CORNER_BR, CORNER_BL};
  localparam bit VTX_U [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam bit VTX_V [6] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    logic    u;
    logic    v;
    logic    last;
    status_e status;
  } vertex_t;

  // Basis copy, vertex prediction and the queue of vertices still to come
  class vertex_scoreboard;
    vertex_t expected_q[$];
    axis_t   right_ax[3];
    axis_t   up_ax[3];
    int      fails;

    function new();
      right_ax = '{Q14_ONE, Q14_ZERO, Q14_ZERO};
      up_ax    = '{Q14_ZERO, Q14_ONE, Q14_ZERO};
      fails    = 0;
    endfunction

    function void write_axis(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_RIGHT_X: right_ax[0] = data;
        REG_RIGHT_Y: right_ax[1] = data;
        REG_RIGHT_Z: right_ax[2] = data;
        REG_UP_X:    up_ax[0] = data;
        REG_UP_Y:    up_ax[1] = data;
        REG_UP_Z:    up_ax[2] = data;
        default: ;
      endcase
    endfunction

    // Q16.16 times Q2.14 is Q18.30; round half up back to Q16.16
    function longint scale_q14(longint a, axis_t b);
      return (a * longint'(b) + longint'(ROUND_BIAS)) >>> 14;
    endfunction

    function bit in_word(longint x);
      return x == longint'(int'(x));
    endfunction

    function bit beyond_tol(longint d);
      return (d < 0 ? -d : d) > longint'(BASIS_TOL);
    endfunction

    function void note_request(coord_t fx, coord_t fy, coord_t fz, coord_t lo,
                               coord_t wd, coord_t ht);
      longint  foot[3];
      longint  c[4][3];
      longint  rr, uu, ru, redge;
      status_e st;
      vertex_t vtx;
      int      i, k;
      foot[0] = longint'(fx);
      foot[1] = longint'(fy);
      foot[2] = longint'(fz);
      rr = 0;
      uu = 0;
      ru = 0;
      for (i = 0; i < 3; i++) begin
        rr += longint'(right_ax[i]) * longint'(right_ax[i]);
        uu += longint'(up_ax[i]) * longint'(up_ax[i]);
        ru += longint'(right_ax[i]) * longint'(up_ax[i]);
      end
      st = ST_OK;
      // Basis check first, then size, then range of the edges and corners
      if (beyond_tol(rr - longint'(BASIS_ONE)) || beyond_tol(uu - longint'(BASIS_ONE)) ||
          beyond_tol(ru)) begin
        st = ST_BAD_BASIS;
      end else if (wd <= 0 || ht <= 0) begin
        st = ST_BAD_SIZE;
      end else begin
        redge = longint'(lo) + longint'(wd);
        if (!in_word(redge)) begin
          st = ST_OVERFLOW;
        end else begin
          for (i = 0; i < 3; i++) begin
            c[CORNER_BL][i] = foot[i] + scale_q14(longint'(lo), right_ax[i]);
            c[CORNER_BR][i] = foot[i] + scale_q14(redge, right_ax[i]);
            // top corners build on the already rounded bottom corners
            c[CORNER_TL][i] = c[CORNER_BL][i] + scale_q14(longint'(ht), up_ax[i]);
            c[CORNER_TR][i] = c[CORNER_BR][i] + scale_q14(longint'(ht), up_ax[i]);
            if (!in_word(c[CORNER_BL][i]) || !in_word(c[CORNER_BR][i]) ||
                !in_word(c[CORNER_TL][i]) || !in_word(c[CORNER_TR][i])) st = ST_OVERFLOW;
          end
        end
      end
      if (st != ST_OK) begin
        vtx        = '0;
        vtx.last   = 1'b1;
        vtx.status = st;
        expected_q.push_back(vtx);
      end else begin
        for (k = 0; k < 6; k++) begin
          vtx.x      = coord_t'(c[VTX_CORNER[k]][0]);
          vtx.y      = coord_t'(c[VTX_CORNER[k]][1]);
          vtx.z      = coord_t'(c[VTX_CORNER[k]][2]);
          vtx.u      = VTX_U[k];
          vtx.v      = VTX_V[k];
          vtx.last   = (k == 5);
          vtx.status = ST_OK;
          expected_q.push_back(vtx);
        end
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fails++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (expected_q.size() == 0) begin
        fails++;
        $display("%0t: vertex with nothing expected, expected none, actual x %h y %h z %h st %0d",
                 $time, got.x, got.y, got.z, got.status);
        return;
      end
      want = expected_q.pop_front();
      check_field("vertex_x", want.x, got.x);
      check_field("vertex_y", want.y, got.y);
      check_field("vertex_z", want.z, got.z);
      check_field("tex_u", 32'(want.u), 32'(got.u));
      check_field("tex_v", 32'(want.v), 32'(got.v));
      check_field("last", 32'(want.last), 32'(got.last));
      check_field("status", 32'(want.status), 32'(got.status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] foot_x_i;
  logic [31:0] foot_y_i;
  logic [31:0] foot_z_i;
  logic [31:0] left_offset_i;
  logic [31:0] quad_width_i;
  logic [31:0] quad_height_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] vertex_x_o;
  logic [31:0] vertex_y_o;
  logic [31:0] vertex_z_o;
  logic        tex_u_o;
  logic        tex_v_o;
  logic        last_o;
  logic [1:0]  status_o;

  vertex_scoreboard quads = new();
  vertex_t     seen_vtx;
  int unsigned accepted_reqs = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  billboard_quad_vertex_expander i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .foot_x_i,
    .foot_y_i,
    .foot_z_i,
    .left_offset_i,
    .quad_width_i,
    .quad_height_i,
    .out_valid_o,
    .out_ready_i,
    .vertex_x_o,
    .vertex_y_o,
    .vertex_z_o,
    .tex_u_o,
    .tex_v_o,
    .last_o,
    .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample every handshake at the rising edge: note requests, track register
  // writes, check vertices. Inputs only move at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      quads.note_request(foot_x_i, foot_y_i, foot_z_i, left_offset_i, quad_width_i,
                         quad_height_i);
      accepted_reqs <= accepted_reqs + 1;
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) quads.write_axis(cfg_index_i, cfg_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_vtx.x      = vertex_x_o;
      seen_vtx.y      = vertex_y_o;
      seen_vtx.z      = vertex_z_o;
      seen_vtx.u      = tex_u_o;
      seen_vtx.v      = tex_v_o;
      seen_vtx.last   = last_o;
      seen_vtx.status = status_e'(status_o);
      quads.check_vertex(seen_vtx);
    end
  end

  // Receiver: random stalls, plus one long hold-off once enough requests went
  // in, so the pipeline fills up and drops in_ready_o while the sender keeps
  // offering requests.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!hold_done && accepted_reqs >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request at the falling edge and hold it until taken. Valid stays
  // high on return so back-to-back requests never drop it within a step.
  task automatic send_request(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] fz, input logic [31:0] lo,
                              input logic [31:0] wd, input logic [31:0] ht);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    foot_x_i      <= fx;
    foot_y_i      <= fy;
    foot_z_i      <= fz;
    left_offset_i <= lo;
    quad_width_i  <= wd;
    quad_height_i <= ht;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // A plain request that passes under any usable basis
  task automatic send_probe(input logic [31:0] wd);
    send_request(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'hFFFF_8000, wd,
                 32'h0002_0000);
  endtask

  // Drop valid and wait until every expected vertex has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (quads.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Reprogram the whole basis while idle; also poke the unused indexes
  task automatic apply_basis(input axis_t rx, input axis_t ry, input axis_t rz,
                             input axis_t ux, input axis_t uy, input axis_t uz);
    drain();
    write_reg(REG_RIGHT_X, rx);
    write_reg(REG_RIGHT_Y, ry);
    write_reg(REG_RIGHT_Z, rz);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
    write_reg(IDX_SPARE_LO, 16'($urandom));
    write_reg(IDX_SPARE_HI, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly usable bases: signed axis permutations with a slight tilt, or a
  // 45 degree turn; now and then a garbage basis with extreme components.
  task automatic random_basis();
    axis_t rv[3];
    axis_t uv[3];
    int    mode, a, b, i;
    mode = $urandom_range(0, 9);
    for (i = 0; i < 3; i++) begin
      rv[i] = Q14_ZERO;
      uv[i] = Q14_ZERO;
    end
    if (mode == 0) begin
      for (i = 0; i < 3; i++) begin
        case ($urandom_range(0, 2))
          0:       rv[i] = 16'sh8000;
          1:       rv[i] = 16'sh7FFF;
          default: rv[i] = 16'($urandom);
        endcase
        uv[i] = 16'($urandom);
      end
    end else if (mode == 1) begin
      rv[0] = 16'sd11585;
      rv[1] = 16'sd11585;
      uv[0] = -16'sd11585;
      uv[1] = 16'sd11585;
    end else begin
      a = $urandom_range(0, 2);
      b = (a + $urandom_range(1, 2)) % 3;
      rv[a] = $urandom_range(0, 1) ? Q14_ONE : -Q14_ONE;
      uv[b] = $urandom_range(0, 1) ? Q14_ONE : -Q14_ONE;
      rv[b] = 16'($urandom_range(0, 8));
    end
    apply_basis(rv[0], rv[1], rv[2], uv[0], uv[1], uv[2]);
  endtask

  // Most requests are well formed with random content; the rest are raw
  // noise, nonpositive sizes, or points pressed against the Q16.16 edge.
  task automatic random_request();
    logic [31:0] f[3];
    logic [31:0] lo, wd, ht;
    int          mode, i;
    mode = $urandom_range(0, 99);
    for (i = 0; i < 3; i++) f[i] = 32'($signed($urandom) >>> 8);
    lo = 32'($signed($urandom) >>> 12);
    wd = $urandom_range(1, 32'h0010_0000);
    ht = $urandom_range(1, 32'h0010_0000);
    if (mode >= 70 && mode < 82) begin
      for (i = 0; i < 3; i++) f[i] = $urandom;
      lo = $urandom;
      wd = $urandom;
      ht = $urandom;
    end else if (mode >= 82 && mode < 90) begin
      if ($urandom_range(0, 1)) wd = 32'd0 - $urandom_range(0, 32'h8000_0000);
      else ht = 32'd0 - $urandom_range(0, 32'h8000_0000);
    end else if (mode >= 90) begin
      f[$urandom_range(0, 2)] = $urandom_range(0, 1) ?
                                32'h7FFF_FFFF - $urandom_range(0, 32'h0003_FFFF) :
                                32'h8000_0000 + $urandom_range(0, 32'h0003_FFFF);
      wd = $urandom_range(1, 32'h0002_0000);
      ht = $urandom_range(1, 32'h0002_0000);
    end
    send_request(f[0], f[1], f[2], lo, wd, ht);
  endtask

  initial begin
    int chunk, phase;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    foot_x_i      = '0;
    foot_y_i      = '0;
    foot_z_i      = '0;
    left_offset_i = '0;
    quad_width_i  = '0;
    quad_height_i = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 67;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests under the reset basis (right = x, up = y)
    send_request(32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    // right edge of x just past the top of the range
    send_request(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1);
    // left corner below the bottom of the range
    send_request(32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h1);
    // top corners overflow in y
    send_request(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1, 32'h1);
    // every foot at the negative limit, still fits
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h1, 32'h1);
    // nonpositive sizes
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0001_0000);
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // right edge itself leaves the range
    send_request(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h1);
    // widest spans that still fit
    send_request(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h2AAA_AAAA, 32'h5555_5555);

    // Unusable basis: zero right axis; it wins over a bad size too
    apply_basis(Q14_ZERO, Q14_ZERO, Q14_ZERO, Q14_ZERO, Q14_ONE, Q14_ZERO);
    send_probe(32'h0001_0000);
    send_probe(32'h0);
    // Components at their extremes
    apply_basis(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_probe(32'h0001_0000);
    // Length just inside, then just outside the tolerance
    apply_basis(16'sd16392, Q14_ZERO, Q14_ZERO, Q14_ZERO, 16'sd16376, Q14_ZERO);
    send_probe(32'h0001_0000);
    apply_basis(16'sd16393, Q14_ZERO, Q14_ZERO, Q14_ZERO, Q14_ONE, Q14_ZERO);
    send_probe(32'h0001_0000);
    // Skew just inside, then just outside the tolerance
    apply_basis(Q14_ONE, Q14_ZERO, Q14_ZERO, 16'sd16, Q14_ONE, Q14_ZERO);
    send_probe(32'h0001_0000);
    apply_basis(Q14_ONE, Q14_ZERO, Q14_ZERO, 16'sd17, Q14_ONE, Q14_ZERO);
    send_probe(32'h0001_0000);
    // Flipped axes pointing along -x and -z
    apply_basis(-Q14_ONE, Q14_ZERO, Q14_ZERO, Q14_ZERO, Q14_ZERO, -Q14_ONE);
    send_probe(32'h0003_8000);

    // Random part: three idling profiles, several basis settings each
    for (chunk = 0; chunk < 3; chunk++) begin
      for (phase = 0; phase < 3; phase++) begin
        random_basis();
        // change the idling profile only while everything is quiet
        case (chunk)
          0: begin
            send_idle_pct = 35;
            recv_idle_pct = 67;
          end
          1: begin
            send_idle_pct = 67;
            recv_idle_pct = 35;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        repeat (PHASE_ITEMS) random_request();
      end
    end

    drain();
    if (quads.fails == 0 && quads.pending() == 0) begin
      $display("billboard_quad_vertex_expander verification clean");
    end else begin
      $display("billboard_quad_vertex_expander verification failed");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("billboard_quad_vertex_expander verification failed");
    $finish;
  end

endmodule
